>>> rtl/core/brw_pkg.sv
// Shared types and constants for the base relocation walker.
// No dependencies; every other file of the block imports this package.
package brw_pkg;

  // Reset values of the configuration registers.
  localparam logic [63:0] LOAD_BASE_RST      = 64'h0000_0000_0800_0000;
  localparam logic [63:0] PREFERRED_BASE_RST = 64'h0;

  // Configuration register indexes.
  localparam logic CFG_LOAD_BASE      = 1'b0;
  localparam logic CFG_PREFERRED_BASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_PATCH     = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  // Relocation entry types.
  localparam logic [3:0] TYPE_ABSOLUTE = 4'd0;
  localparam logic [3:0] TYPE_DIR64    = 4'd10;

  // Block header length in bytes.
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  // Walk phases.
  localparam logic [2:0] PH_PAGE_LO = 3'd0;
  localparam logic [2:0] PH_PAGE_HI = 3'd1;
  localparam logic [2:0] PH_SIZE_LO = 3'd2;
  localparam logic [2:0] PH_SIZE_HI = 3'd3;
  localparam logic [2:0] PH_ENTRY   = 3'd4;

  // Classified halfword handed from the decoder to the address stage.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page;
    logic [11:0] offset;
    logic [3:0]  bad_type;
    logic        failed;
    logic        done;
  } brw_rec_t;

  localparam int unsigned REC_W = $bits(brw_rec_t);

endpackage

>>> rtl/core/brw_front.sv
// Decoder of the relocation walker: holds the walk state and classifies each halfword.
// Depends on brw_pkg.
module brw_front
  import brw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        delta_nz,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_half_word,
  input  logic        in_end_of_directory,
  output logic        rec_valid,
  input  logic        rec_ready,
  output brw_rec_t    rec
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] page_r, page_nxt;
  logic [30:0] entries_r, entries_nxt;
  logic        stopped_r, stopped_nxt;
  logic        error_r, error_nxt;
  logic [15:0] size_lo_r, size_lo_nxt;

  logic [31:0] size;
  logic [31:0] body_bytes;
  logic [3:0]  etype;
  logic        accept;

  assign in_ready  = rec_ready;
  assign rec_valid = in_valid;
  assign accept    = in_valid && rec_ready;

  assign size       = {in_half_word, size_lo_r};
  assign body_bytes = size - HEADER_BYTES;
  assign etype      = in_half_word[15:12];

  // Walk state update and classification of the current halfword.
  always_comb begin
    phase_nxt    = phase_r;
    page_nxt     = page_r;
    entries_nxt  = entries_r;
    stopped_nxt  = stopped_r;
    error_nxt    = error_r;
    size_lo_nxt  = size_lo_r;
    rec.status   = ST_NONE;
    rec.page     = page_r;
    rec.offset   = in_half_word[11:0];
    rec.bad_type = 4'd0;
    if (delta_nz && !stopped_r) begin
      case (phase_r)
        PH_PAGE_LO: begin
          page_nxt  = {16'd0, in_half_word};
          phase_nxt = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          page_nxt  = {in_half_word, page_r[15:0]};
          phase_nxt = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          size_lo_nxt = in_half_word;
          phase_nxt   = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          phase_nxt = PH_PAGE_LO;
          if (size == 32'd0) begin
            stopped_nxt = 1'b1;
          end else if (size < HEADER_BYTES || size[0]) begin
            rec.status  = ST_MALFORMED;
            error_nxt   = 1'b1;
            stopped_nxt = 1'b1;
          end else begin
            entries_nxt = body_bytes[31:1];
            if (body_bytes[31:1] != 31'd0) begin
              phase_nxt = PH_ENTRY;
            end
          end
        end
        default: begin
          // Entry halfword: padding, a 64-bit patch, or an unsupported type.
          if (etype == TYPE_ABSOLUTE) begin
            rec.status = ST_NONE;
          end else if (etype == TYPE_DIR64) begin
            rec.status = ST_PATCH;
          end else begin
            rec.status   = ST_BAD_TYPE;
            rec.bad_type = etype;
            error_nxt    = 1'b1;
            stopped_nxt  = 1'b1;
          end
          if (entries_r != 31'd0) begin
            entries_nxt = entries_r - 31'd1;
          end
          if (stopped_nxt || entries_nxt == 31'd0) begin
            phase_nxt = PH_PAGE_LO;
          end
        end
      endcase
    end
    rec.failed = delta_nz && error_nxt;
    rec.done   = in_end_of_directory;
  end

  // Walk state registers; the end of a directory returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PAGE_LO;
      page_r    <= 32'd0;
      entries_r <= 31'd0;
      stopped_r <= 1'b0;
      error_r   <= 1'b0;
      size_lo_r <= 16'd0;
    end else if (accept) begin
      if (in_end_of_directory) begin
        phase_r   <= PH_PAGE_LO;
        page_r    <= 32'd0;
        entries_r <= 31'd0;
        stopped_r <= 1'b0;
        error_r   <= 1'b0;
        size_lo_r <= 16'd0;
      end else begin
        phase_r   <= phase_nxt;
        page_r    <= page_nxt;
        entries_r <= entries_nxt;
        stopped_r <= stopped_nxt;
        error_r   <= error_nxt;
        size_lo_r <= size_lo_nxt;
      end
    end
  end

endmodule

>>> rtl/core/brw_fifo.sv
// Small register queue between the decoder and the address stage.
// Depends on brw_pkg for the default record width REC_W.
module brw_fifo
  import brw_pkg::*;
#(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = REC_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/brw_back.sv
// Address stage of the relocation walker: forms the patch address and holds the result.
// Depends on brw_pkg.
module brw_back
  import brw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] load_base,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  brw_rec_t    rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_patch_address,
  output logic [3:0]  out_bad_type,
  output logic        out_failed,
  output logic        out_done_res
);

  logic        valid_r;
  logic [1:0]  status_r;
  logic [63:0] addr_r, addr_nxt;
  logic [3:0]  bad_type_r;
  logic        failed_r;
  logic        done_r;
  logic        take;

  assign rec_ready = !valid_r || out_ready;
  assign take      = rec_valid && rec_ready;

  // Patch address is load base plus page plus offset, wrapping at 64 bits; zero for other results.
  always_comb begin
    addr_nxt = 64'd0;
    if (rec.status == ST_PATCH) begin
      addr_nxt = load_base + {32'd0, rec.page} + {52'd0, rec.offset};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_ready) begin
      valid_r <= rec_valid;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      status_r   <= rec.status;
      addr_r     <= addr_nxt;
      bad_type_r <= rec.bad_type;
      failed_r   <= rec.failed;
      done_r     <= rec.done;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_patch_address = addr_r;
  assign out_bad_type      = bad_type_r;
  assign out_failed        = failed_r;
  assign out_done_res      = done_r;

endmodule

>>> rtl/core/base_relocation_walker.sv
// Base relocation walker: one request per halfword in, one result per halfword out.
// Each accepted halfword is registered first in the queue and then in the address register.
// Throughput: one halfword per cycle while the queue has room to take it.
// The two-entry queue lets the decoder keep taking requests while a result waits.
// Synchronous active-low reset clears the walk, the queue and the result stage and
// restores the configuration registers to their reset values. Depends on brw_pkg.
module base_relocation_walker
  import brw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_half_word,
  input  logic        in_end_of_directory,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_patch_address,
  output logic [3:0]  out_bad_type,
  output logic        out_failed,
  output logic        out_done_res
);

  logic [63:0] load_base_r;
  logic [63:0] preferred_base_r;
  logic        delta_nz;

  logic        f_valid, f_ready;
  brw_rec_t    f_rec;
  logic        q_valid, q_ready;
  logic [REC_W-1:0] q_data;
  brw_rec_t    q_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r      <= LOAD_BASE_RST;
      preferred_base_r <= PREFERRED_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOAD_BASE:      load_base_r      <= cfg_wdata;
        CFG_PREFERRED_BASE: preferred_base_r <= cfg_wdata;
        default:            load_base_r      <= load_base_r;
      endcase
    end
  end

  // A zero delta leaves the walk untouched.
  assign delta_nz = (load_base_r != preferred_base_r);

  brw_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .delta_nz            (delta_nz),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_half_word        (in_half_word),
    .in_end_of_directory (in_end_of_directory),
    .rec_valid           (f_valid),
    .rec_ready           (f_ready),
    .rec                 (f_rec)
  );

  brw_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (REC_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_rec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_rec = brw_rec_t'(q_data);

  brw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_base         (load_base_r),
    .rec_valid         (q_valid),
    .rec_ready         (q_ready),
    .rec               (q_rec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_patch_address (out_patch_address),
    .out_bad_type      (out_bad_type),
    .out_failed        (out_failed),
    .out_done_res      (out_done_res)
  );

endmodule

>>> rtl/core/brw_checker.sv
// Port-level checks for the base relocation walker, bound to the top level.
// Depends on brw_pkg.
module brw_checker
  import brw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_patch_address,
  input logic [3:0]  out_bad_type,
  input logic        out_failed
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_patch_address))
    else $error("result dropped or changed while stalled");

  // Only a patch result carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PATCH |-> out_patch_address == 64'd0)
    else $error("address on a result that is not a patch");

  // Only an unsupported type result carries a type, and it is never padding or DIR64.
  a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_TYPE |->
      out_bad_type != TYPE_ABSOLUTE && out_bad_type != TYPE_DIR64)
    else $error("unsupported type result with a supported type");

  a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BAD_TYPE |-> out_bad_type == 4'd0)
    else $error("type reported on a result that is not a type error");

  // Every error result marks the walk as failed.
  a_err_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_TYPE || out_status == ST_MALFORMED) |-> out_failed)
    else $error("error result without failed flag");

endmodule

bind base_relocation_walker brw_checker u_brw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_patch_address (out_patch_address),
  .out_bad_type      (out_bad_type),
  .out_failed        (out_failed)
);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for base_relocation_walker: directed and random relocation directories.
// Depends on brw_pkg and the walker RTL; carries its own model of the walk to predict each result.
module tb_top;
  import brw_pkg::*;

  // One halfword request and one predicted result.
  typedef struct packed {
    logic        eod;
    logic [15:0] hw;
  } halfword_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] patch_address;
    logic [3:0]  bad_type;
    logic        failed;
    logic        done_res;
  } reloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_LOAD_BASE;
  logic [63:0] cfg_wdata = 64'h0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_half_word = 16'h0;
  logic        in_end_of_directory = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_patch_address;
  logic [3:0]  out_bad_type;
  logic        out_failed;
  logic        out_done_res;

  base_relocation_walker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_half_word        (in_half_word),
    .in_end_of_directory (in_end_of_directory),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_patch_address   (out_patch_address),
    .out_bad_type        (out_bad_type),
    .out_failed          (out_failed),
    .out_done_res        (out_done_res)
  );

  // Bench copy of the configuration and of the walk state.
  logic [63:0] cur_load_base = LOAD_BASE_RST;
  logic [63:0] cur_pref_base = PREFERRED_BASE_RST;
  logic [2:0]  walk_phase = PH_PAGE_LO;
  logic [31:0] walk_page = 32'h0;
  logic [30:0] walk_left = 31'h0;
  logic        walk_stopped = 1'b0;
  logic        walk_error = 1'b0;
  logic [15:0] walk_size_lo = 16'h0;

  halfword_item_t halfword_q[$];
  halfword_item_t dir_build[$];
  reloc_result_t  predicted_results[$];

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned stall_left = 0;
  logic        no_idle = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the walk by one halfword and return the result it should produce.
  function automatic reloc_result_t walk_halfword(input logic [15:0] hw, input logic eod);
    reloc_result_t r;
    logic [31:0]   blk_size;
    logic [3:0]    etype;
    r = '0;
    if (cur_load_base != cur_pref_base && !walk_stopped) begin
      case (walk_phase)
        PH_PAGE_LO: begin
          walk_page = {16'h0, hw};
          walk_phase = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          walk_page[31:16] = hw;
          walk_phase = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          walk_size_lo = hw;
          walk_phase = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          blk_size = {hw, walk_size_lo};
          walk_phase = PH_PAGE_LO;
          if (blk_size == 32'h0) begin
            walk_stopped = 1'b1;
          end else if (blk_size < HEADER_BYTES || blk_size[0]) begin
            r.status = ST_MALFORMED;
            walk_error = 1'b1;
            walk_stopped = 1'b1;
          end else begin
            blk_size = (blk_size - HEADER_BYTES) >> 1;
            walk_left = blk_size[30:0];
            if (walk_left != 31'h0) walk_phase = PH_ENTRY;
          end
        end
        default: begin
          etype = hw[15:12];
          if (etype == TYPE_DIR64) begin
            r.status = ST_PATCH;
            r.patch_address = cur_load_base + {32'h0, walk_page} + {52'h0, hw[11:0]};
          end else if (etype != TYPE_ABSOLUTE) begin
            r.status = ST_BAD_TYPE;
            r.bad_type = etype;
            walk_error = 1'b1;
            walk_stopped = 1'b1;
          end
          if (walk_left != 31'h0) walk_left = walk_left - 31'd1;
          if (walk_stopped || walk_left == 31'h0) walk_phase = PH_PAGE_LO;
        end
      endcase
    end
    r.failed = (cur_load_base != cur_pref_base) && walk_error;
    r.done_res = eod;
    // The end of a directory puts the walk back to its starting point.
    if (eod) begin
      walk_phase = PH_PAGE_LO;
      walk_page = 32'h0;
      walk_left = 31'h0;
      walk_stopped = 1'b0;
      walk_error = 1'b0;
      walk_size_lo = 16'h0;
    end
    return r;
  endfunction

  // Request driver: offers queued halfwords and predicts each one as it is accepted.
  always @(posedge clk) begin : drive_requests
    halfword_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready)
        predicted_results.push_back(walk_halfword(in_half_word, in_end_of_directory));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (halfword_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          item = halfword_q.pop_front();
          in_half_word <= item.hw;
          in_end_of_directory <= item.eod;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    reloc_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        // One long hold-off lets the walker fill up and push back on requests.
        if (results_seen == 150) stall_left = 120;
        if (predicted_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_patch_address !== want.patch_address) begin
            $error("patch_address mismatch: expected %h, got %h",
                   want.patch_address, out_patch_address);
            fail_count++;
          end
          if (out_bad_type !== want.bad_type) begin
            $error("bad_type mismatch: expected %0d, got %0d", want.bad_type, out_bad_type);
            fail_count++;
          end
          if (out_failed !== want.failed) begin
            $error("failed mismatch: expected %0d, got %0d", want.failed, out_failed);
            fail_count++;
          end
          if (out_done_res !== want.done_res) begin
            $error("done_res mismatch: expected %0d, got %0d", want.done_res, out_done_res);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic put_hw(input logic [15:0] hw, input logic eod);
    dir_build.push_back({eod, hw});
  endtask

  task automatic put_word(input logic [31:0] w);
    put_hw(w[15:0], 1'b0);
    put_hw(w[31:16], 1'b0);
  endtask

  // Build one random directory: mostly well-formed blocks, some broken, cut short or noise.
  task automatic add_directory();
    int          kind;
    int          nblk;
    int          nent;
    int          cut;
    logic [31:0] page;
    logic [31:0] bsize;
    logic [3:0]  etype;
    dir_build.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // Raw noise with scattered directory ends.
      repeat ($urandom_range(1, 20)) put_hw(16'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      nblk = $urandom_range(1, 4);
      for (int b = 0; b < nblk; b++) begin
        page = $urandom;
        if ($urandom_range(0, 7) == 0) page = 32'h0;
        else if ($urandom_range(0, 7) == 0) page = 32'hffff_ffff;
        bsize = 32'd8 + 32'd2 * 32'($urandom_range(0, 8));
        nent = (bsize - 32'd8) / 2;
        if (b == nblk - 1 && kind < 15) begin
          // Huge block that only a directory end can close.
          bsize = $urandom | 32'h8000_0000;
          bsize[0] = 1'b0;
          nent = $urandom_range(1, 12);
        end else if (b == nblk - 1 && kind < 22) begin
          // Malformed size: nonzero and either below the header length or odd.
          bsize = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(1, 7)) : ($urandom | 32'h1);
          nent = $urandom_range(0, 2);
        end
        put_word(page);
        put_word(bsize);
        for (int e = 0; e < nent; e++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: etype = TYPE_DIR64;
            12, 13, 14, 15, 16: etype = TYPE_ABSOLUTE;
            17: begin
              do etype = 4'($urandom); while (etype == TYPE_ABSOLUTE || etype == TYPE_DIR64);
            end
            default: etype = 4'($urandom);
          endcase
          put_hw({etype, 12'($urandom)}, 1'b0);
        end
      end
      // Well-formed walks close with a zero-size block, sometimes followed by stray data.
      if (kind >= 22 && $urandom_range(0, 9) != 0) begin
        put_word($urandom);
        put_word(32'h0);
        repeat ($urandom_range(0, 2)) put_hw(16'($urandom), 1'b0);
      end
      if (kind < 35) begin
        cut = $urandom_range(1, dir_build.size());
        while (dir_build.size() > cut) void'(dir_build.pop_back());
      end
    end
    dir_build[dir_build.size() - 1].eod = 1'b1;
    foreach (dir_build[i]) halfword_q.push_back(dir_build[i]);
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned target;
    target = halfword_q.size() + count;
    while (halfword_q.size() < target) add_directory();
  endtask

  // Wait until every request is accepted and every result checked, then let the pipe empty.
  task automatic drain();
    @(negedge clk);
    while (halfword_q.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bases(input logic [63:0] load_v, input logic [63:0] pref_v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LOAD_BASE;
    cfg_wdata <= load_v;
    @(posedge clk);
    cfg_index <= CFG_PREFERRED_BASE;
    cfg_wdata <= pref_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_load_base = load_v;
    cur_pref_base = pref_v;
  endtask

  // Main sequence: reset, directed walk under reset bases, then random phases per setting.
  initial begin : stimulus
    logic [63:0] same_base;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Block at the top page with the largest offset, padding and a zero offset.
    dir_build.delete();
    put_word(32'hffff_ffff);
    put_word(32'd14);
    put_hw({TYPE_DIR64, 12'hfff}, 1'b0);
    put_hw({TYPE_ABSOLUTE, 12'h000}, 1'b0);
    put_hw({TYPE_DIR64, 12'h000}, 1'b0);
    // Empty block, then a block whose entry has an unsupported type.
    put_word(32'h0);
    put_word(32'd8);
    put_word(32'h0000_1000);
    put_word(32'd10);
    put_hw({4'hf, 12'h123}, 1'b0);
    put_hw(16'hffff, 1'b1);
    // Size below the header length, a stray halfword after the stop, then a clean zero end.
    put_word(32'h0);
    put_word(32'd7);
    put_hw(16'h1234, 1'b1);
    put_word(32'h0);
    put_word(32'h0);
    dir_build[dir_build.size() - 1].eod = 1'b1;
    foreach (dir_build[i]) halfword_q.push_back(dir_build[i]);
    add_random(300);
    drain();

    // Zero delta: the walker ignores everything.
    set_bases(64'h0, 64'h0);
    add_random(60);
    drain();

    set_bases(64'hffff_ffff_ffff_ffff, 64'h0);
    add_random(400);
    drain();

    set_bases({$urandom, $urandom}, {$urandom, $urandom});
    add_random(400);
    drain();

    set_bases(64'h0, 64'hffff_ffff_ffff_ffff);
    add_random(400);
    drain();

    same_base = {$urandom, $urandom};
    set_bases(same_base, same_base);
    add_random(60);
    drain();

    // Last stretch runs with both sides always ready.
    no_idle = 1'b1;
    set_bases({$urandom, $urandom}, 64'h0);
    add_random(450);
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
